>>> hw/rtl/indexed_list_engine_top_assert.svh
// assertion helpers used by the list engine top module
`ifndef INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_ENGINE_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define ILE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a property in the next cycle
`define ILE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ile_pkg.sv
package ile_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int ST_W     = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LEVELS   = $clog2(CAPACITY);
  localparam int LEAVES   = 1 << LEVELS;
  localparam int WAIT_W   = $clog2(LEVELS) + 1;

  localparam logic [DATA_W-1:0] MAX_NEUTRAL = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SUM    = 3'd3,
    OP_SUFMAX = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  // what the cells present to the reduction tree
  typedef enum logic [1:0] {
    RED_SUM  = 2'd0,
    RED_MAX  = 2'd1,
    RED_PICK = 2'd2
  } red_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2
  } fsm_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic  ins;
    logic  del;
    red_e  red;
    cmp_t  pos;
    cmp_t  cnt;
    data_t value;
  } cell_ctrl_t;

  function automatic data_t neutral(red_e red);
    data_t n;
    n = (red == RED_MAX) ? MAX_NEUTRAL : '0;
    return n;
  endfunction

  function automatic data_t combine(red_e red, data_t a, data_t b);
    data_t r;
    if (red == RED_MAX) begin
      r = ($signed(a) >= $signed(b)) ? a : b;
    end else begin
      r = a + b;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ile_req_if.sv
interface ile_req_if;
  logic                           valid;
  logic                           ready;
  logic [ile_pkg::OP_W-1:0]       opcode;
  logic [ile_pkg::POS_W-1:0]      position;
  logic signed [ile_pkg::DATA_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

>>> hw/rtl/ile_rsp_if.sv
interface ile_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ile_pkg::ST_W-1:0]          status;
  logic signed [ile_pkg::DATA_W-1:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

>>> hw/rtl/ile_cell.sv
module ile_cell (
  input  logic                clk_i,
  input  ile_pkg::cell_ctrl_t ctrl_i,
  input  ile_pkg::cmp_t       idx_i,
  input  ile_pkg::data_t      left_i,
  input  ile_pkg::data_t      right_i,
  output ile_pkg::data_t      data_o,
  output ile_pkg::data_t      leaf_o
);

  ile_pkg::data_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      // open a gap at pos, everything behind it moves one cell up
      if (idx_i > ctrl_i.pos) begin
        data_q <= left_i;
      end else if (idx_i == ctrl_i.pos) begin
        data_q <= ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      if (idx_i >= ctrl_i.pos) begin
        data_q <= right_i;
      end
    end
  end

  always_comb begin
    case (ctrl_i.red)
      ile_pkg::RED_SUM: begin
        leaf_o = (idx_i < ctrl_i.cnt) ? data_q : '0;
      end
      ile_pkg::RED_MAX: begin
        leaf_o = (idx_i >= ctrl_i.pos && idx_i < ctrl_i.cnt) ? data_q
                                                               : ile_pkg::MAX_NEUTRAL;
      end
      ile_pkg::RED_PICK: begin
        leaf_o = (idx_i == ctrl_i.pos) ? data_q : '0;
      end
      default: begin
        leaf_o = '0;
      end
    endcase
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/ile_tree.sv
module ile_tree (
  input  logic           clk_i,
  input  ile_pkg::red_e  red_i,
  input  ile_pkg::data_t leaf_i [ile_pkg::CAPACITY],
  output ile_pkg::data_t root_o
);

  ile_pkg::data_t leaf_w [ile_pkg::LEAVES];
  ile_pkg::data_t node_q [1:ile_pkg::LEAVES-1];

  for (genvar j = 0; j < ile_pkg::LEAVES; j++) begin : g_leaf
    if (j < ile_pkg::CAPACITY) begin : g_real
      assign leaf_w[j] = leaf_i[j];
    end else begin : g_pad
      assign leaf_w[j] = ile_pkg::neutral(red_i);
    end
  end

  // heap order: node i combines 2i and 2i+1, one register per level
  for (genvar i = 1; i < ile_pkg::LEAVES; i++) begin : g_node
    if (2 * i >= ile_pkg::LEAVES) begin : g_bottom
      always_ff @(posedge clk_i) begin
        node_q[i] <= ile_pkg::combine(red_i, leaf_w[2*i-ile_pkg::LEAVES],
                                      leaf_w[2*i+1-ile_pkg::LEAVES]);
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        node_q[i] <= ile_pkg::combine(red_i, node_q[2*i], node_q[2*i+1]);
      end
    end
  end

  assign root_o = node_q[1];

endmodule

>>> hw/rtl/indexed_list_engine_top.sv
// Ordered list of up to ile_pkg::CAPACITY signed 32-bit values, held in a row of
// cells that shift toward or away from an index together. One request is in
// flight at a time: append, insert and every rejected request are latched, then
// executed, which loads their response; sum, suffix maximum and delete wait
// until the registered reduction tree that gathers the cells has settled, and
// delete shifts the cells in the cycle its response is loaded. A response that
// is not taken holds the engine until it is. No clearing is needed after reset.
`include "indexed_list_engine_top_assert.svh"

module indexed_list_engine_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ile_req_if.sink   req_i,
  ile_rsp_if.source rsp_o
);

  ile_pkg::fsm_e  state_q, state_d;
  logic [ile_pkg::OP_W-1:0]  req_op_q;
  logic [ile_pkg::POS_W-1:0] req_pos_q;
  ile_pkg::data_t            req_val_q;
  logic [ile_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [ile_pkg::WAIT_W-1:0] wait_q, wait_d;

  logic                      rsp_valid_q;
  logic [ile_pkg::ST_W-1:0]  rsp_status_q;
  ile_pkg::data_t            rsp_val_q;

  logic                in_ready;
  logic                out_load;
  logic                slot_free;
  logic                full;
  ile_pkg::st_e        st_res;
  ile_pkg::data_t      res_val;
  ile_pkg::cmp_t       pos_x;
  ile_pkg::cmp_t       cnt_x;
  ile_pkg::cell_ctrl_t ctrl;
  ile_pkg::data_t      tree_root;

  ile_pkg::data_t cell_data [ile_pkg::CAPACITY];
  ile_pkg::data_t cell_leaf [ile_pkg::CAPACITY];

  assign pos_x     = ile_pkg::CMP_W'(req_pos_q);
  assign cnt_x     = ile_pkg::CMP_W'(cnt_q);
  assign full      = cnt_q >= ile_pkg::CNT_W'(ile_pkg::CAPACITY);
  assign slot_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    wait_d     = wait_q;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    st_res     = ile_pkg::ST_OK;
    res_val    = '0;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pos   = pos_x;
    ctrl.cnt   = cnt_x;
    ctrl.value = req_val_q;
    case (ile_pkg::op_e'(req_op_q))
      ile_pkg::OP_DELETE: ctrl.red = ile_pkg::RED_PICK;
      ile_pkg::OP_SUFMAX: ctrl.red = ile_pkg::RED_MAX;
      default:            ctrl.red = ile_pkg::RED_SUM;
    endcase

    case (state_q)
      ile_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid) begin
          state_d = ile_pkg::S_EXEC;
        end
      end
      ile_pkg::S_EXEC: begin
        case (ile_pkg::op_e'(req_op_q))
          ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
            if (slot_free) begin
              out_load = 1'b1;
              state_d  = ile_pkg::S_IDLE;
              // range check wins over the full check for insert
              if (ile_pkg::op_e'(req_op_q) == ile_pkg::OP_INSERT && pos_x > cnt_x) begin
                st_res = ile_pkg::ST_RANGE;
              end else if (full) begin
                st_res = ile_pkg::ST_FULL;
              end else begin
                ctrl.ins = 1'b1;
                if (ile_pkg::op_e'(req_op_q) == ile_pkg::OP_APPEND) begin
                  ctrl.pos = cnt_x;
                end
                cnt_d = cnt_q + ile_pkg::CNT_W'(1);
              end
            end
          end
          ile_pkg::OP_DELETE, ile_pkg::OP_SUFMAX: begin
            if (pos_x >= cnt_x) begin
              if (slot_free) begin
                out_load = 1'b1;
                st_res   = ile_pkg::ST_RANGE;
                state_d  = ile_pkg::S_IDLE;
              end
            end else begin
              wait_d  = '0;
              state_d = ile_pkg::S_WAIT;
            end
          end
          ile_pkg::OP_SUM: begin
            wait_d  = '0;
            state_d = ile_pkg::S_WAIT;
          end
          default: begin
            if (slot_free) begin
              out_load = 1'b1;
              st_res   = ile_pkg::ST_RANGE;
              state_d  = ile_pkg::S_IDLE;
            end
          end
        endcase
      end
      ile_pkg::S_WAIT: begin
        // tree root is settled once every level has been clocked
        if (wait_q == ile_pkg::WAIT_W'(ile_pkg::LEVELS - 1)) begin
          if (slot_free) begin
            out_load = 1'b1;
            res_val  = tree_root;
            state_d  = ile_pkg::S_IDLE;
            if (ile_pkg::op_e'(req_op_q) == ile_pkg::OP_DELETE) begin
              ctrl.del = 1'b1;
              cnt_d    = cnt_q - ile_pkg::CNT_W'(1);
            end
          end
        end else begin
          wait_d = wait_q + ile_pkg::WAIT_W'(1);
        end
      end
      default: begin
        state_d = ile_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ile_pkg::S_IDLE;
      cnt_q       <= '0;
      wait_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      req_op_q  <= req_i.opcode;
      req_pos_q <= req_i.position;
      req_val_q <= req_i.value;
    end
    if (out_load) begin
      rsp_status_q <= st_res;
      rsp_val_q    <= res_val;
    end
  end

  for (genvar k = 0; k < ile_pkg::CAPACITY; k++) begin : g_cell
    ile_pkg::data_t left_w;
    ile_pkg::data_t right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == ile_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    ile_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (ile_pkg::CMP_W'(k)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .leaf_o  (cell_leaf[k])
    );
  end

  ile_tree u_tree (
    .clk_i  (clk_i),
    .red_i  (ctrl.red),
    .leaf_i (cell_leaf),
    .root_o (tree_root)
  );

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.result_value = $signed(rsp_val_q);

  `ILE_CHECK(a_cnt_range, cnt_q <= ile_pkg::CNT_W'(ile_pkg::CAPACITY), "count above capacity")
  `ILE_CHECK(a_one_shift, !(ctrl.ins && ctrl.del), "insert and delete shift together")
  `ILE_CHECK(a_shift_reports, !(ctrl.ins || ctrl.del) || out_load, "shift without response")
  `ILE_NEXT(a_cnt_hold, !(ctrl.ins || ctrl.del), $stable(cnt_q), "count moved without shift")
  `ILE_CHECK(a_wait_reduce, state_q != ile_pkg::S_WAIT || req_op_q == ile_pkg::OP_SUM || req_op_q == ile_pkg::OP_SUFMAX || req_op_q == ile_pkg::OP_DELETE, "reduce wait on wrong opcode")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ile_pkg::*;

  localparam int RAND_ITEMS     = 1930;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 500;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_DIRECTED     = 23;

  // opcodes with no meaning, the block must reject them
  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_e;

  typedef struct packed {
    st_e   status;
    data_t value;
  } list_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    data_t            val;
    logic             typed;
    st_e              st;
    data_t            res;
  } dir_row_t;

  // typed rows carry their expected response, the rest go through the predictor
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{OP_SUM,      6'd0,  32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
    '{OP_DELETE,   6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_SUFMAX,   6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_INSERT,   6'd1,  32'h0000_0005, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_INSERT,   6'd0,  32'h7fff_ffff, 1'b1, ST_OK,    32'h0000_0000},
    '{OP_APPEND,   6'd63, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
    '{OP_APPEND,   6'd0,  32'hffff_ffff, 1'b1, ST_OK,    32'h0000_0000},
    '{OP_SUFMAX,   6'd0,  32'h0000_0000, 1'b1, ST_OK,    32'h7fff_ffff},
    '{OP_SUFMAX,   6'd1,  32'hffff_ffff, 1'b1, ST_OK,    32'hffff_ffff},
    '{OP_SUM,      6'd63, 32'h0000_0000, 1'b1, ST_OK,    32'hffff_fffe},
    '{OP_RSVD_LO,  6'd2,  32'h0000_1234, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_RSVD_MID, 6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_RSVD_HI,  6'd63, 32'hffff_ffff, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_DELETE,   6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_SUFMAX,   6'd3,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_INSERT,   6'd4,  32'h0000_0001, 1'b1, ST_RANGE, 32'h0000_0000},
    '{OP_INSERT,   6'd3,  32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
    '{OP_INSERT,   6'd1,  32'h0000_0001, 1'b0, ST_OK,    32'h0000_0000},
    '{OP_DELETE,   6'd2,  32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000},
    '{OP_SUFMAX,   6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{OP_DELETE,   6'd0,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{OP_SUM,      6'd0,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{OP_DELETE,   6'd2,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000}
  };

  data_t corner_values [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};

  logic clk = 1'b0;
  logic rst_n;

  ile_req_if req ();
  ile_rsp_if rsp ();

  indexed_list_engine_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the list, advanced on every accepted request
  data_t     list_cells [CAPACITY];
  int        list_len;
  list_rsp_t pending_list_results [$];

  int n_errors;
  int n_accepted;
  int n_responses;
  int quiet_cycles;
  bit hold_rsp;
  int ready_wait;
  int ready_tick;

  function automatic list_rsp_t list_request(input logic [OP_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input data_t val);
    list_rsp_t r;
    data_t     acc;
    int        at;
    r.status = ST_OK;
    r.value  = '0;
    at       = int'(pos);
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_cells[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (at > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k > at; k--) list_cells[k] = list_cells[k-1];
          list_cells[at] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (at >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value = list_cells[at];
          for (int k = at; k < list_len - 1; k++) list_cells[k] = list_cells[k+1];
          list_len--;
        end
      end
      OP_SUM: begin
        acc = '0;
        for (int k = 0; k < list_len; k++) acc = acc + list_cells[k];
        r.value = acc;
      end
      OP_SUFMAX: begin
        if (at >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          acc = list_cells[at];
          for (int k = at + 1; k < list_len; k++) begin
            if ($signed(list_cells[k]) > $signed(acc)) acc = list_cells[k];
          end
          r.value = acc;
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    return r;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(input mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_RSVD_LO + 3'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 45) return OP_APPEND;
        if (r < 85) return OP_INSERT;
        if (r < 90) return OP_DELETE;
        if (r < 95) return OP_SUM;
        return OP_SUFMAX;
      end
      MIX_SHRINK: begin
        if (r < 60) return OP_DELETE;
        if (r < 75) return OP_SUFMAX;
        if (r < 85) return OP_SUM;
        if (r < 93) return OP_INSERT;
        return OP_APPEND;
      end
      default: begin
        if (r < 20) return OP_APPEND;
        if (r < 40) return OP_INSERT;
        if (r < 60) return OP_DELETE;
        if (r < 75) return OP_SUM;
        return OP_SUFMAX;
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return POS_W'($urandom_range(0, 63));
    if (r < 30) return POS_W'(list_len);
    if (op == OP_INSERT) return POS_W'($urandom_range(0, list_len));
    if (list_len > 0) return POS_W'($urandom_range(0, list_len - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic data_t pick_value();
    if ($urandom_range(0, 99) < 15) return corner_values[$urandom_range(0, 4)];
    return data_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input data_t got, input data_t want);
    n_errors++;
    $display("mismatch in %s of response %0d: got %h, expected %h",
             what, n_responses, got, want);
  endtask

  // valid stays high across back to back transactions
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input data_t val, input int gap,
                               input logic typed, input list_rsp_t typed_rsp);
    list_rsp_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.position <= pos;
    req.value    <= val;
    do @(posedge clk); while (!(req.valid && req.ready));
    predicted = list_request(op, pos, val);
    pending_list_results.push_back(typed ? typed_rsp : predicted);
    n_accepted++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rsp.valid && rsp.ready) begin
        if (pending_list_results.size() == 0) begin
          report_mismatch("unexpected response", data_t'(rsp.status), rsp.result_value);
        end else begin
          list_rsp_t want;
          want = pending_list_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", data_t'(rsp.status), data_t'(want.status));
          if (rsp.result_value !== want.value)
            report_mismatch("result_value", rsp.result_value, want.value);
        end
        n_responses++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      ready_tick++;
      if (hold_rsp || ready_wait > 0) begin
        rsp.ready <= 1'b0;
        if (ready_wait > 0) ready_wait--;
      end else begin
        rsp.ready <= 1'b1;
        // in every fourth stretch of ready ticks no new random stall is started
        if ((ready_tick / 500) % 4 != 3 && $urandom_range(0, 4) == 0) ready_wait = idle_len();
      end
    end
  end

  // long receiver stall so that the engine backs up into the request channel
  initial begin
    hold_rsp = 1'b0;
    do @(negedge clk); while (n_accepted < HOLD_AFTER);
    @(posedge clk);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    list_rsp_t typed_rsp;
    mix_e      mix;
    int        span;
    int        sent;
    bit        calm;
    logic [OP_W-1:0] op;

    rst_n        = 1'b0;
    req.valid    = 1'b0;
    req.opcode   = OP_APPEND;
    req.position = '0;
    req.value    = '0;
    list_len     = 0;
    n_errors     = 0;
    n_accepted   = 0;
    n_responses  = 0;
    quiet_cycles = 0;
    ready_wait   = 0;
    ready_tick   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_rsp.status = dir_rows[i].st;
      typed_rsp.value  = dir_rows[i].res;
      offer_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val, idle_len(),
                    dir_rows[i].typed, typed_rsp);
    end

    // phases that fill, drain or churn the list, so full and empty both recur
    typed_rsp = '0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      mix  = mix_e'($urandom_range(0, 2));
      span = $urandom_range(8, 64);
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < span && sent < RAND_ITEMS; i++) begin
        op = pick_opcode(mix);
        offer_request(op, pick_position(op), pick_value(), calm ? 0 : idle_len(),
                      1'b0, typed_rsp);
        sent++;
      end
    end
    @(negedge clk);
    req.valid <= 1'b0;

    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
